/* rtl/core/rglc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglc_pkg
// Shared types, codes and constants of the RGB lamp command controller.
// ----------------------------------------------------------------------------
package rglc_pkg;

  // lamp table size and field widths
  localparam int NUM_LAMPS = 8;
  localparam int LAMP_W    = 3;
  localparam int STEP_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // fixed levels
  localparam logic [7:0] WHITE_LIM  = 8'hF0;
  localparam logic [7:0] FULL_LEVEL = 8'hFF;

  // register reset values
  localparam logic [STEP_W-1:0] STEP_RST    = 7'd10;
  localparam logic [7:0]        DEFAULT_RST = 8'd128;
  localparam logic [7:0]        MAX_RST     = 8'd255;
  localparam logic [7:0]        MIN_RST     = 8'd0;

  // command codes
  localparam logic [7:0] CMD_TOGGLE    = 8'h01;
  localparam logic [7:0] CMD_ON        = 8'h02;
  localparam logic [7:0] CMD_OFF       = 8'h03;
  localparam logic [7:0] CMD_UP        = 8'h10;
  localparam logic [7:0] CMD_DOWN      = 8'h20;
  localparam logic [7:0] CMD_SET       = 8'h22;
  localparam logic [7:0] CMD_NIGHT_THR = 8'h30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP    = 2'd0,
    CFG_DEFAULT = 2'd1,
    CFG_MAX     = 2'd2,
    CFG_MIN     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_NIGHT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_SWITCH_ON  = 3'd0,
    ACT_SWITCH_OFF = 3'd1,
    ACT_BRIGHT     = 3'd2,
    ACT_WHITE      = 3'd3,
    ACT_RGB        = 3'd4
  } action_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    mode_t      mode;
    rgb_t       stored;
    logic [7:0] bright;
  } lamp_state_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [7:0]        bdefault;
    logic [7:0]        bmax;
    logic [7:0]        bmin;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [LAMP_W-1:0] lamp;
    logic [7:0]        command;
    rgb_t              color;
  } item_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    action_t           action;
    logic [7:0]        bright;
    rgb_t              color;
    mode_t             mode;
    logic              changed;
    logic              last;
  } result_t;

endpackage

/* rtl/core/rglc_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rglc_exec
// Decodes one word for one lamp and works out the lamp's next state and up
// to two bulb actions.
// ----------------------------------------------------------------------------
module rglc_exec (
  input  rglc_pkg::item_t       item_i,
  input  rglc_pkg::lamp_state_t cur_i,
  input  rglc_pkg::cfg_t        cfg_i,
  output rglc_pkg::lamp_state_t nxt_o,
  output rglc_pkg::result_t     res0_o,
  output rglc_pkg::result_t     res1_o,
  output logic [1:0]            num_o
);
  import rglc_pkg::*;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_ON,
    OP_OFF,
    OP_UP,
    OP_DOWN
  } op_t;

  function automatic logic is_white(rgb_t c);
    return (c.red >= WHITE_LIM) && (c.green >= WHITE_LIM) && (c.blue >= WHITE_LIM);
  endfunction

  function automatic logic [7:0] max3(rgb_t c);
    logic [7:0] m;
    m = c.red;
    if (c.green > m) m = c.green;
    if (c.blue > m) m = c.blue;
    return m;
  endfunction

  // channel + (brightness - largest channel), clamped to 0..lim
  function automatic logic [7:0] scale_ch(logic [7:0] c, logic [7:0] br,
                                          logic [7:0] base, logic [7:0] lim);
    logic signed [9:0] v;
    v = $signed({2'b00, c}) + $signed({2'b00, br}) - $signed({2'b00, base});
    if (v > $signed({2'b00, lim})) return lim;
    else if (v < 10'sd0) return 8'h00;
    else return v[7:0];
  endfunction

  // brightness for white, scaled color otherwise
  function automatic result_t level_res(rgb_t st, logic [7:0] br, logic [7:0] lim);
    result_t r;
    logic [7:0] base;
    r    = '0;
    base = max3(st);
    if (is_white(st)) begin
      r.action = ACT_BRIGHT;
      r.bright = br;
    end else begin
      r.action      = ACT_RGB;
      r.color.red   = scale_ch(st.red, br, base, lim);
      r.color.green = scale_ch(st.green, br, base, lim);
      r.color.blue  = scale_ch(st.blue, br, base, lim);
    end
    return r;
  endfunction

  op_t        op;
  logic [7:0] lim;
  logic [8:0] min_plus;
  logic       above_min;
  logic       up_ok;
  logic       night_req;
  logic       changed;
  result_t    r0;
  result_t    r1;
  logic [1:0] num;
  lamp_state_t nxt;

  // shared limits and compares
  assign lim       = (WHITE_LIM - 8'd1) - {1'b0, cfg_i.step};
  assign min_plus  = {1'b0, cfg_i.bmin} + {2'b00, cfg_i.step};
  assign above_min = {1'b0, cur_i.bright} > min_plus;
  assign up_ok     = ({1'b0, cur_i.bright} + {2'b00, cfg_i.step}) < {1'b0, cfg_i.bmax};
  assign night_req = item_i.command > CMD_NIGHT_THR;

  // command and tick decode
  always_comb begin
    op = OP_NONE;
    if (int'(item_i.lamp) < NUM_LAMPS) begin
      if (item_i.func) begin
        if (night_req || (cur_i.mode == MODE_NIGHT)) begin
          op = above_min ? OP_DOWN : OP_OFF;
        end
      end else begin
        case (item_i.command)
          CMD_TOGGLE: begin
            if (cur_i.mode == MODE_OFF) op = OP_ON;
            else if (cur_i.mode == MODE_ON) op = OP_OFF;
            else op = OP_NONE;
          end
          CMD_ON:   op = OP_ON;
          CMD_OFF:  op = OP_OFF;
          CMD_UP:   op = OP_UP;
          CMD_DOWN: op = OP_DOWN;
          CMD_SET:  op = OP_SET;
          default:  op = OP_NONE;
        endcase
      end
    end
  end

  // state update and actions
  always_comb begin
    nxt     = cur_i;
    r0      = '0;
    r1      = '0;
    num     = 2'd0;
    changed = 1'b0;
    if (item_i.func && night_req && (int'(item_i.lamp) < NUM_LAMPS)) begin
      nxt.mode = MODE_NIGHT;
    end
    case (op)
      OP_SET: begin
        nxt.stored = item_i.color;
        nxt.mode   = MODE_ON;
        if (is_white(item_i.color)) begin
          nxt.bright = cfg_i.bdefault;
          r0.action  = ACT_WHITE;
          r1.action  = ACT_BRIGHT;
          r1.bright  = cfg_i.bdefault;
          num        = 2'd2;
        end else begin
          nxt.bright = max3(item_i.color);
          r0.action  = ACT_RGB;
          r0.color   = item_i.color;
          num        = 2'd1;
        end
      end
      OP_OFF: begin
        nxt.mode  = MODE_OFF;
        r0.action = ACT_SWITCH_OFF;
        num       = 2'd1;
        changed   = 1'b1;
      end
      OP_ON: begin
        if (cur_i.stored == '0) begin
          nxt.stored = '{FULL_LEVEL, FULL_LEVEL, FULL_LEVEL};
          nxt.bright = cfg_i.bdefault;
        end
        nxt.mode  = MODE_ON;
        r0.action = ACT_SWITCH_ON;
        r1        = level_res(nxt.stored, nxt.bright, lim);
        num       = 2'd2;
        changed   = 1'b1;
      end
      OP_UP: begin
        if (up_ok) nxt.bright = cur_i.bright + {1'b0, cfg_i.step};
        r0  = level_res(cur_i.stored, nxt.bright, lim);
        num = 2'd1;
      end
      OP_DOWN: begin
        if (above_min) nxt.bright = cur_i.bright - {1'b0, cfg_i.step};
        r0  = level_res(cur_i.stored, nxt.bright, lim);
        num = 2'd1;
      end
      default: begin
        num = 2'd0;
      end
    endcase
    // common fields of every action
    r0.lamp    = item_i.lamp;
    r1.lamp    = item_i.lamp;
    r0.mode    = nxt.mode;
    r1.mode    = nxt.mode;
    r0.changed = changed;
    r1.changed = changed;
    r0.last    = (num == 2'd1);
    r1.last    = 1'b1;
  end

  assign nxt_o  = nxt;
  assign res0_o = r0;
  assign res1_o = r1;
  assign num_o  = num;

endmodule

/* rtl/core/rgb_lamp_command_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_lamp_command_controller
// Per-lamp state for eight RGB bulbs; turns commands and good-night ticks
// into bulb actions.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per command or timer tick, valid/ready handshake.
//   out_* : bulb actions, valid/ready, one word per cycle while out_ready is high; out_last marks the
//           final action of a word (a word gives zero, one or two actions).
//   cfg_* : write-only registers (step, default, max, min brightness),
//           written with cfg_we while the block is idle.
// Data path: an accepted word is held in the input register and decoded
//   against the lamp table in the next cycle; its actions go into the
//   result register once that has room, and the first of them is then
//   valid at the output.
// Throughput: one word per cycle while each word gives at most one action
//   and out_ready is high; after a two-action word (on, toggle to on,
//   white set) the next word waits for the single output port to drain it.
// Reset: all lamps off with zero color and brightness 128, registers at
//   their defaults, no action pending.
// Stall: while out_ready is low the results stay put; the input register
//   then holds one more word and in_ready drops.
// ----------------------------------------------------------------------------
module rgb_lamp_command_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [rglc_pkg::LAMP_W-1:0]    in_lamp,
  input  logic [7:0]                     in_command,
  input  logic [7:0]                     in_red_in,
  input  logic [7:0]                     in_green_in,
  input  logic [7:0]                     in_blue_in,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rglc_pkg::LAMP_W-1:0]    out_lamp_out,
  output logic [2:0]                     out_action,
  output logic [7:0]                     out_bright_out,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic [1:0]                     out_mode_out,
  output logic                           out_changed,
  output logic                           out_last,
  // configuration port
  input  logic                           cfg_we,
  input  logic [rglc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rglc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rglc_pkg::*;

  cfg_t        cfg_r;
  logic        s1_valid_r;
  item_t       s1_item_r;
  mode_t       mode_r   [NUM_LAMPS];
  rgb_t        stored_r [NUM_LAMPS];
  logic [7:0]  bright_r [NUM_LAMPS];
  result_t     q_r      [2];
  result_t     q_nxt    [2];
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  lamp_state_t cur;
  lamp_state_t nxt;
  result_t     res0;
  result_t     res1;
  logic [1:0]  num;
  logic        pop;
  logic        s1_fire;
  logic        in_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step     <= STEP_RST;
      cfg_r.bdefault <= DEFAULT_RST;
      cfg_r.bmax     <= MAX_RST;
      cfg_r.bmin     <= MIN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STEP:    cfg_r.step     <= cfg_data[STEP_W-1:0];
        CFG_DEFAULT: cfg_r.bdefault <= cfg_data;
        CFG_MAX:     cfg_r.bmax     <= cfg_data;
        CFG_MIN:     cfg_r.bmin     <= cfg_data;
        default:     cfg_r          <= cfg_r;
      endcase
    end
  end

  // handshakes
  assign pop      = out_valid && out_ready;
  assign s1_fire  = s1_valid_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop));
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func    <= in_func;
      s1_item_r.lamp    <= in_lamp;
      s1_item_r.command <= in_command;
      s1_item_r.color   <= '{in_red_in, in_green_in, in_blue_in};
    end
  end

  // lamp table read
  assign cur.mode   = mode_r[s1_item_r.lamp];
  assign cur.stored = stored_r[s1_item_r.lamp];
  assign cur.bright = bright_r[s1_item_r.lamp];

  rglc_exec u_exec (
    .item_i (s1_item_r),
    .cur_i  (cur),
    .cfg_i  (cfg_r),
    .nxt_o  (nxt),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (num)
  );

  // lamp table write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LAMPS; i++) begin
        mode_r[i]   <= MODE_OFF;
        stored_r[i] <= '0;
        bright_r[i] <= DEFAULT_RST;
      end
    end else if (s1_fire) begin
      mode_r[s1_item_r.lamp]   <= nxt.mode;
      stored_r[s1_item_r.lamp] <= nxt.stored;
      bright_r[s1_item_r.lamp] <= nxt.bright;
    end
  end

  // two-entry result register, head at entry 0
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (s1_fire) begin
      q_nxt[0] = res0;
      q_nxt[1] = res1;
      cnt_nxt  = num;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // result outputs
  assign out_valid      = (cnt_r != 2'd0);
  assign out_lamp_out   = q_r[0].lamp;
  assign out_action     = q_r[0].action;
  assign out_bright_out = q_r[0].bright;
  assign out_red_out    = q_r[0].color.red;
  assign out_green_out  = q_r[0].color.green;
  assign out_blue_out   = q_r[0].color.blue;
  assign out_mode_out   = q_r[0].mode;
  assign out_changed    = q_r[0].changed;
  assign out_last       = q_r[0].last;

`ifndef SYNTH
  // result register never holds more than two actions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result count out of range");

  // first of two pending actions is never the last of its word
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !q_r[0].last)
    else $error("pending pair head marked last");

  // a single pending action always closes its word
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> q_r[0].last)
    else $error("single pending action not marked last");

  // a held word is not dropped while the result register is busy
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("held input word lost");

  // lamp mode on the output is always a defined mode
  a_mode_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode_out != 2'd3))
    else $error("undefined lamp mode on output");
`endif

endmodule
